// ===== hw/rtl/polyphonic_voice_allocator_unit_macros.svh =====
// Assertion macros used by the voice allocator back end (pva_back).
// Expects signals named clk and rst_n in the including scope.
`ifndef POLYPHONIC_VOICE_ALLOCATOR_UNIT_MACROS_SVH
`define POLYPHONIC_VOICE_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define PVA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define PVA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/pva_pkg.sv =====
// Shared types and constants of the voice allocator.
// No dependencies; used by pva_front, pva_back and the top level.
`timescale 1ns / 1ps

package pva_pkg;

  // Default sizes handed to the top level parameters
  localparam int NUM_SLOTS_DEF  = 16;
  localparam int STAMP_BITS_DEF = 32;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Field widths
  localparam int NOTE_W = 7;
  localparam int VEL_W  = 7;
  localparam int FIN_W  = 4;
  localparam int SLOT_OUT_W = 4;
  localparam int MODE_W = 2;
  localparam int LIMIT_W = 5;
  localparam int CFG_IDX_W = 1;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  // Event codes
  typedef enum logic [1:0] {
    FUNC_NOTE_ON    = 2'd0,
    FUNC_NOTE_OFF   = 2'd1,
    FUNC_ALL_OFF    = 2'd2,
    FUNC_VOICE_DONE = 2'd3
  } func_t;

  // Play modes; anything but polyphonic acts as mono
  localparam logic [MODE_W-1:0] MODE_POLY = 2'd2;

  // Result actions
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STOP  = 1'b1;

  // Register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_VOICE_MODE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_VOICE_LIMIT = 1'b1;
  localparam logic [MODE_W-1:0]    VOICE_MODE_RST  = 2'd2;
  localparam logic [LIMIT_W-1:0]   VOICE_LIMIT_RST = 5'd8;

  // Classified command passed from front to back
  typedef struct packed {
    func_t             kind;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  velocity;
    logic [FIN_W-1:0]  fin_slot;
  } cmd_t;

endpackage

// ===== hw/rtl/polyphonic_voice_allocator_unit.sv =====
// Path: a start, or a stop from a note-off, passes the command queue and then the output register
// (back end idle); stealing in poly mode first runs the stamp scan over the usable slots.
// All-notes-off: one stop beat a cycle per active slot, ascending, while the output does not stall.
// Throughput: input beats are taken every cycle until the 2-entry command queue fills.
// Reset (rst_n low, synchronous): all slots inactive, stamp counter zero,
// voice mode polyphonic, voice limit 8; no clearing pass is needed.
`timescale 1ns / 1ps

module polyphonic_voice_allocator_unit #(
  parameter int NUM_SLOTS  = pva_pkg::NUM_SLOTS_DEF,
  parameter int STAMP_BITS = pva_pkg::STAMP_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [6:0] note, [13:7] velocity, [17:14] finished_slot, rest zero
  input  logic [pva_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [1:0] func
  input  logic [1:0]                        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [3:0] slot, [10:4] slot_note, [17:11] slot_velocity, rest zero
  output logic [pva_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // [0] action, [1] replaced
  output logic [1:0]                        out_tuser,
  output logic                              out_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pva_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pva_pkg::LIMIT_W-1:0]       cfg_data
);

  logic [pva_pkg::MODE_W-1:0]  voice_mode_r;
  logic [pva_pkg::LIMIT_W-1:0] voice_limit_r;
  logic                        q_valid, q_ready;
  pva_pkg::cmd_t               q_cmd;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      voice_mode_r  <= pva_pkg::VOICE_MODE_RST;
      voice_limit_r <= pva_pkg::VOICE_LIMIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        pva_pkg::REG_VOICE_MODE:  voice_mode_r  <= cfg_data[pva_pkg::MODE_W-1:0];
        pva_pkg::REG_VOICE_LIMIT: voice_limit_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  pva_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_cmd     (q_cmd)
  );

  pva_back #(
    .NUM_SLOTS  (NUM_SLOTS),
    .STAMP_BITS (STAMP_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_cmd       (q_cmd),
    .voice_mode  (voice_mode_r),
    .voice_limit (voice_limit_r),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

endmodule

// ===== hw/rtl/pva_front.sv =====
// Front end: accepts input beats, classifies them and queues commands.
// Depends on pva_pkg.
`timescale 1ns / 1ps

module pva_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [6:0] note, [13:7] velocity, [17:14] finished_slot, rest zero
  input  logic [pva_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [1:0] func
  input  logic [1:0]                       in_tuser,
  output logic                             q_valid,
  input  logic                             q_ready,
  output pva_pkg::cmd_t                    q_cmd
);

  pva_pkg::cmd_t                    fifo_r [pva_pkg::QUEUE_DEPTH];
  logic [pva_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [pva_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [pva_pkg::QCNT_W-1:0]       cnt_r, cnt_nxt;
  pva_pkg::cmd_t                    cmd_in;
  logic                             push, pop;

  // Classify: a note-on with zero velocity is a note-off
  always_comb begin
    cmd_in.kind     = pva_pkg::func_t'(in_tuser[1:0]);
    cmd_in.note     = in_tdata[6:0];
    cmd_in.velocity = in_tdata[13:7];
    cmd_in.fin_slot = in_tdata[17:14];
    if (cmd_in.kind == pva_pkg::FUNC_NOTE_ON && cmd_in.velocity == '0) begin
      cmd_in.kind = pva_pkg::FUNC_NOTE_OFF;
    end
  end

  assign in_tready = (cnt_r != pva_pkg::QCNT_W'(pva_pkg::QUEUE_DEPTH));
  assign q_valid   = (cnt_r != '0);
  assign q_cmd     = fifo_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = q_valid && q_ready;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == pva_pkg::QPTR_W'(pva_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == pva_pkg::QPTR_W'(pva_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

// ===== hw/rtl/pva_back.sv =====
// Back end: slot table, oldest-stamp scan and result emission.
// Depends on pva_pkg and polyphonic_voice_allocator_unit_macros.svh.
`timescale 1ns / 1ps

`include "polyphonic_voice_allocator_unit_macros.svh"

module pva_back #(
  parameter int NUM_SLOTS  = pva_pkg::NUM_SLOTS_DEF,
  parameter int STAMP_BITS = pva_pkg::STAMP_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  output logic                              q_ready,
  input  pva_pkg::cmd_t                     q_cmd,
  input  logic [pva_pkg::MODE_W-1:0]        voice_mode,
  input  logic [pva_pkg::LIMIT_W-1:0]       voice_limit,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [3:0] slot, [10:4] slot_note, [17:11] slot_velocity, rest zero
  output logic [pva_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // [0] action, [1] replaced
  output logic [1:0]                        out_tuser,
  output logic                              out_tlast
);

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int LIM_W  = $clog2(NUM_SLOTS + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  typedef struct packed {
    logic                           action;
    logic [pva_pkg::SLOT_OUT_W-1:0] slot;
    logic [pva_pkg::NOTE_W-1:0]     note;
    logic [pva_pkg::VEL_W-1:0]      velocity;
    logic                           replaced;
    logic                           last;
  } res_t;

  state_t                     state_r, state_nxt;
  logic [NUM_SLOTS-1:0]       active_r, active_nxt;
  logic [NUM_SLOTS-1:0]       rem_r, rem_nxt;
  logic [pva_pkg::NOTE_W-1:0] note_r [NUM_SLOTS];
  logic [STAMP_BITS-1:0]      stamp_mem [NUM_SLOTS];
  logic [STAMP_BITS-1:0]      stamp_cnt_r;
  logic [STAMP_BITS-1:0]      rd_data_r;
  logic [SLOT_W-1:0]          rd_addr;
  logic                       rd_vld_r, rd_vld_nxt;
  logic [LIM_W-1:0]           rd_idx_r, rd_idx_nxt;
  logic [LIM_W-1:0]           scan_idx_r, scan_idx_nxt;
  logic [SLOT_W-1:0]          best_idx_r, best_idx_nxt;
  logic [STAMP_BITS-1:0]      best_stamp_r, best_stamp_nxt;
  logic                       steal_rdy_r, steal_rdy_nxt;
  logic [LIM_W-1:0]           lim;
  logic [NUM_SLOTS-1:0]       use_vec, free_vec, match_vec;
  logic [SLOT_W-1:0]          free_idx, act_idx, match_idx, rem_idx;
  logic [SLOT_W-1:0]          sel_idx, stop_idx;
  logic [NUM_SLOTS-1:0]       rem_clr;
  logic                       out_ld_ok, out_ld, start_we, cand_better, poly_start;
  logic                       out_valid_r;
  res_t                       res, out_r;

  // Lowest set bit of a slot vector
  function automatic logic [SLOT_W-1:0] first_set(input logic [NUM_SLOTS-1:0] v);
    logic [SLOT_W-1:0] r;
    r = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (v[i]) r = SLOT_W'(i);
    end
    return r;
  endfunction

  // Clamp the voice limit to 1..NUM_SLOTS
  always_comb begin
    if (voice_limit == '0) begin
      lim = LIM_W'(1);
    end else if (32'(voice_limit) > NUM_SLOTS) begin
      lim = LIM_W'(NUM_SLOTS);
    end else begin
      lim = LIM_W'(voice_limit);
    end
  end

  // Per-slot status vectors and priority picks
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      use_vec[i]   = (LIM_W'(i) < lim);
      match_vec[i] = active_r[i] && (note_r[i] == q_cmd.note);
    end
    free_vec  = use_vec & ~active_r;
    free_idx  = first_set(free_vec);
    act_idx   = first_set(active_r);
    match_idx = first_set(match_vec);
    rem_idx   = first_set(rem_r);
  end

  assign out_ld_ok   = !out_valid_r || out_tready;
  assign cand_better = (rd_idx_r == '0) || (rd_data_r < best_stamp_r);
  assign poly_start  = start_we && (voice_mode == pva_pkg::MODE_POLY);

  // Command sequencer
  always_comb begin
    state_nxt      = state_r;
    active_nxt     = active_r;
    rem_nxt        = rem_r;
    rd_vld_nxt     = 1'b0;
    rd_idx_nxt     = rd_idx_r;
    scan_idx_nxt   = scan_idx_r;
    best_idx_nxt   = best_idx_r;
    best_stamp_nxt = best_stamp_r;
    steal_rdy_nxt  = steal_rdy_r;
    rd_addr        = SLOT_W'(scan_idx_r);
    q_ready        = 1'b0;
    out_ld         = 1'b0;
    start_we       = 1'b0;
    sel_idx        = '0;
    stop_idx       = match_idx;
    rem_clr        = '0;
    res            = '0;

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          case (q_cmd.kind)
            pva_pkg::FUNC_NOTE_ON: begin
              if (voice_mode != pva_pkg::MODE_POLY) begin
                sel_idx  = (|active_r) ? act_idx : '0;
                start_we = out_ld_ok;
              end else if (|free_vec) begin
                sel_idx  = free_idx;
                start_we = out_ld_ok;
              end else if (steal_rdy_r) begin
                sel_idx  = best_idx_r;
                start_we = out_ld_ok;
              end else begin
                scan_idx_nxt = '0;
                state_nxt    = ST_SCAN;
              end
              if (start_we) begin
                out_ld        = 1'b1;
                q_ready       = 1'b1;
                steal_rdy_nxt = 1'b0;
                res.action    = pva_pkg::ACT_START;
                res.slot      = pva_pkg::SLOT_OUT_W'(sel_idx);
                res.note      = q_cmd.note;
                res.velocity  = q_cmd.velocity;
                res.replaced  = active_r[sel_idx];
                res.last      = 1'b1;
                for (int i = 0; i < NUM_SLOTS; i++) begin
                  if (SLOT_W'(i) == sel_idx) active_nxt[i] = 1'b1;
                end
              end
            end
            pva_pkg::FUNC_NOTE_OFF: begin
              if (!(|match_vec)) begin
                q_ready = 1'b1;
              end else if (out_ld_ok) begin
                q_ready      = 1'b1;
                out_ld       = 1'b1;
                res.action   = pva_pkg::ACT_STOP;
                res.slot     = pva_pkg::SLOT_OUT_W'(match_idx);
                res.note     = note_r[stop_idx];
                res.last     = 1'b1;
              end
            end
            pva_pkg::FUNC_ALL_OFF: begin
              q_ready = 1'b1;
              if (|active_r) begin
                rem_nxt   = active_r;
                state_nxt = ST_EMIT;
              end
            end
            pva_pkg::FUNC_VOICE_DONE: begin
              q_ready = 1'b1;
              for (int i = 0; i < NUM_SLOTS; i++) begin
                if (32'(q_cmd.fin_slot) == i) active_nxt[i] = 1'b0;
              end
            end
            default: begin
              q_ready = 1'b1;
            end
          endcase
        end
      end

      // Walk the usable slots for the smallest stamp, one read a cycle
      ST_SCAN: begin
        if (scan_idx_r < lim) begin
          rd_vld_nxt   = 1'b1;
          rd_idx_nxt   = scan_idx_r;
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
        if (rd_vld_r) begin
          if (cand_better) begin
            best_idx_nxt   = SLOT_W'(rd_idx_r);
            best_stamp_nxt = rd_data_r;
          end
          if (rd_idx_r == lim - 1'b1) begin
            steal_rdy_nxt = 1'b1;
            rd_vld_nxt    = 1'b0;
            state_nxt     = ST_IDLE;
          end
        end
      end

      // One stop per active slot, ascending
      ST_EMIT: begin
        stop_idx = rem_idx;
        if (out_ld_ok) begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            rem_clr[i] = (SLOT_W'(i) == rem_idx);
          end
          rem_nxt    = rem_r & ~rem_clr;
          out_ld     = 1'b1;
          res.action = pva_pkg::ACT_STOP;
          res.slot   = pva_pkg::SLOT_OUT_W'(rem_idx);
          res.note   = note_r[stop_idx];
          res.last   = (rem_nxt == '0);
          if (rem_nxt == '0) state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      active_r    <= '0;
      rem_r       <= '0;
      rd_vld_r    <= 1'b0;
      rd_idx_r    <= '0;
      scan_idx_r  <= '0;
      steal_rdy_r <= 1'b0;
      stamp_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      rem_r       <= rem_nxt;
      rd_vld_r    <= rd_vld_nxt;
      rd_idx_r    <= rd_idx_nxt;
      scan_idx_r  <= scan_idx_nxt;
      steal_rdy_r <= steal_rdy_nxt;
      if (start_we) stamp_cnt_r <= stamp_cnt_r + 1'b1;
      if (out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: scan best, note table, output stage
  always_ff @(posedge clk) begin
    best_idx_r   <= best_idx_nxt;
    best_stamp_r <= best_stamp_nxt;
    if (start_we) note_r[sel_idx] <= q_cmd.note;
    if (out_ld) out_r <= res;
  end

  // Start stamp memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (start_we) stamp_mem[sel_idx] <= stamp_cnt_r + 1'b1;
    rd_data_r <= stamp_mem[rd_addr];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_r.velocity, out_r.note, out_r.slot};
  assign out_tuser  = {out_r.replaced, out_r.action};
  assign out_tlast  = out_r.last;

  `PVA_ASSERT_NOW(a_scan_no_out, state_r == ST_SCAN, !out_ld, "result loaded during scan")
  `PVA_ASSERT_NOW(a_emit_pending, state_r == ST_EMIT, rem_r != '0, "emit with no slot left")
  `PVA_ASSERT_NOW(a_poly_in_limit, poly_start, LIM_W'(sel_idx) < lim, "start past voice limit")
  `PVA_ASSERT_NEXT(a_stamp_step, start_we, stamp_cnt_r == $past(stamp_cnt_r) + 1'b1, "no stamp step")

endmodule

// ===== bench/pva_event_checker.sv =====
// Scoreboard for the voice allocator: watches the event, result and register channels.
// Keeps its own slot table, predicts voice beats and compares them. Depends on pva_pkg.
`timescale 1ns / 1ps

module pva_event_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  // [6:0] note, [13:7] velocity, [17:14] finished_slot, rest zero
  input  logic [pva_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [1:0] func
  input  logic [1:0]                      in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  // [3:0] slot, [10:4] slot_note, [17:11] slot_velocity, rest zero
  input  logic [pva_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [0] action, [1] replaced
  input  logic [1:0]                      out_tuser,
  input  logic                            out_tlast,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [pva_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pva_pkg::LIMIT_W-1:0]     cfg_data,
  output int                              mismatch_count,
  output int                              open_events,
  output int                              events_checked
);

  localparam int VOICES = pva_pkg::NUM_SLOTS_DEF;
  localparam int STAMP_W = pva_pkg::STAMP_BITS_DEF;

  typedef struct packed {
    logic                           action;
    logic [pva_pkg::SLOT_OUT_W-1:0] slot;
    logic [pva_pkg::NOTE_W-1:0]     note;
    logic [pva_pkg::VEL_W-1:0]      velocity;
    logic                           replaced;
    logic                           last;
  } voice_event_t;

  // Voice beats predicted but not yet seen
  voice_event_t awaited_events[$];

  // Shadow slot table and registers
  logic                        voice_on    [VOICES];
  logic [pva_pkg::NOTE_W-1:0]  voice_note  [VOICES];
  logic [STAMP_W-1:0]          voice_stamp [VOICES];
  logic [STAMP_W-1:0]          stamp_now;
  logic [pva_pkg::MODE_W-1:0]  mode_reg;
  logic [pva_pkg::LIMIT_W-1:0] limit_reg;

  int fails = 0;
  int checked = 0;

  // Slot a note-on lands in: mono follows the first active voice,
  // poly takes the first free usable slot, else the oldest stamp
  function automatic int choose_voice();
    int lim;
    int best;
    if (mode_reg != pva_pkg::MODE_POLY) begin
      for (int i = 0; i < VOICES; i++)
        if (voice_on[i]) return i;
      return 0;
    end
    lim = int'(limit_reg);
    if (lim < 1) lim = 1;
    if (lim > VOICES) lim = VOICES;
    for (int i = 0; i < lim; i++)
      if (!voice_on[i]) return i;
    best = 0;
    for (int i = 1; i < lim; i++)
      if (voice_stamp[i] < voice_stamp[best]) best = i;
    return best;
  endfunction

  task automatic forecast_voice_events(input pva_pkg::func_t kind,
                                       input logic [pva_pkg::NOTE_W-1:0] note,
                                       input logic [pva_pkg::VEL_W-1:0] vel,
                                       input logic [pva_pkg::FIN_W-1:0] fin);
    voice_event_t ev;
    int s;
    int last_on;
    pva_pkg::func_t eff;
    eff = kind;
    // zero-velocity note-on is a note-off
    if (eff == pva_pkg::FUNC_NOTE_ON && vel == '0) eff = pva_pkg::FUNC_NOTE_OFF;
    case (eff)
      pva_pkg::FUNC_NOTE_ON: begin
        s = choose_voice();
        ev.action   = pva_pkg::ACT_START;
        ev.slot     = pva_pkg::SLOT_OUT_W'(s);
        ev.note     = note;
        ev.velocity = vel;
        ev.replaced = voice_on[s];
        ev.last     = 1'b1;
        stamp_now      = stamp_now + 1'b1;
        voice_on[s]    = 1'b1;
        voice_note[s]  = note;
        voice_stamp[s] = stamp_now;
        awaited_events.insert(awaited_events.size(), ev);
      end
      pva_pkg::FUNC_NOTE_OFF: begin
        // first active slot holding the note; slot stays active
        for (int i = 0; i < VOICES; i++) begin
          if (voice_on[i] && voice_note[i] == note) begin
            ev.action   = pva_pkg::ACT_STOP;
            ev.slot     = pva_pkg::SLOT_OUT_W'(i);
            ev.note     = voice_note[i];
            ev.velocity = '0;
            ev.replaced = 1'b0;
            ev.last     = 1'b1;
            awaited_events.insert(awaited_events.size(), ev);
            break;
          end
        end
      end
      pva_pkg::FUNC_ALL_OFF: begin
        last_on = -1;
        for (int i = 0; i < VOICES; i++)
          if (voice_on[i]) last_on = i;
        for (int i = 0; i < VOICES; i++) begin
          if (voice_on[i]) begin
            ev.action   = pva_pkg::ACT_STOP;
            ev.slot     = pva_pkg::SLOT_OUT_W'(i);
            ev.note     = voice_note[i];
            ev.velocity = '0;
            ev.replaced = 1'b0;
            ev.last     = (i == last_on);
            awaited_events.insert(awaited_events.size(), ev);
          end
        end
      end
      default: begin
        if (int'(fin) < VOICES) voice_on[fin] = 1'b0;
      end
    endcase
  endtask

  task automatic check_field(input string name, input int expv, input int actv);
    if (expv != actv) begin
      $error("%s mismatch: expected %0d, actual %0d", name, expv, actv);
      fails++;
    end
  endtask

  // Sample all channels at the clock edge
  always @(posedge clk) begin
    voice_event_t want;
    if (!rst_n) begin
      for (int i = 0; i < VOICES; i++) begin
        voice_on[i]    = 1'b0;
        voice_note[i]  = '0;
        voice_stamp[i] = '0;
      end
      stamp_now = '0;
      mode_reg  = pva_pkg::VOICE_MODE_RST;
      limit_reg = pva_pkg::VOICE_LIMIT_RST;
      awaited_events.delete();
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == pva_pkg::REG_VOICE_MODE) mode_reg = cfg_data[pva_pkg::MODE_W-1:0];
        else limit_reg = cfg_data;
      end
      // event beats
      if (in_tvalid && in_tready)
        forecast_voice_events(pva_pkg::func_t'(in_tuser), in_tdata[6:0], in_tdata[13:7],
                              in_tdata[17:14]);
      // voice beats
      if (out_tvalid && out_tready) begin
        if (awaited_events.size() == 0) begin
          $error("unexpected voice beat: slot %0d note %0d",
                 out_tdata[3:0], out_tdata[10:4]);
          fails++;
        end else begin
          want = awaited_events.pop_front();
          check_field("action", want.action, out_tuser[0]);
          check_field("slot", want.slot, out_tdata[3:0]);
          check_field("slot_note", want.note, out_tdata[10:4]);
          check_field("slot_velocity", want.velocity, out_tdata[17:11]);
          check_field("replaced", want.replaced, out_tuser[1]);
          check_field("last", want.last, out_tlast);
          checked++;
        end
      end
    end
    mismatch_count <= fails;
    open_events    <= awaited_events.size();
    events_checked <= checked;
  end

endmodule

// ===== bench/polyphonic_voice_allocator_unit_test.sv =====
// Testbench top for the voice allocator: clock, reset, event and register stimulus, verdict.
// Depends on pva_pkg, polyphonic_voice_allocator_unit and pva_event_checker.
`timescale 1ns / 1ps

module polyphonic_voice_allocator_unit_test;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASES        = 11;
  localparam int PHASE_ITEMS   = 40;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [pva_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic [1:0]                      in_tuser = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [pva_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [1:0]                      out_tuser;
  logic                            out_tlast;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [pva_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [pva_pkg::LIMIT_W-1:0]     cfg_data = '0;

  int mismatch_count;
  int open_events;
  int events_checked;
  int cycle_count = 0;
  int beats_sent = 0;
  int settings_used = 0;
  bit calm = 1'b0;
  logic [pva_pkg::NOTE_W-1:0] note_pool [8];

  always #2 clk = ~clk;

  polyphonic_voice_allocator_unit dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  pva_event_checker checker_i (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .mismatch_count, .open_events, .events_checked
  );

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("polyphonic_voice_allocator_unit test failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    return calm ? 0 : $urandom_range(0, 10);
  endfunction

  // Result side: random stall before each voice beat
  initial begin
    int gap;
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Send one event beat after a random gap; returns at the accepting edge
  task automatic play(input logic [1:0] func, input int note, input int vel, input int fin);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {6'b0, pva_pkg::FIN_W'(fin), pva_pkg::VEL_W'(vel), pva_pkg::NOTE_W'(note)};
    do @(posedge clk); while (!in_tready);
    beats_sent++;
  endtask

  task automatic program_register(input logic [pva_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [pva_pkg::LIMIT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Wait until every predicted voice beat has come back
  task automatic wait_for_results();
    @(posedge clk);
    while (open_events != 0) @(posedge clk);
  endtask

  // Idle point: results drained and silent events flushed
  task automatic drain_results();
    in_tvalid <= 1'b0;
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly note traffic, with releases frequent enough to free slots
  task automatic random_event(input bit use_pool);
    int r;
    int note;
    r = $urandom_range(0, 99);
    note = use_pool ? int'(note_pool[$urandom_range(0, 7)]) : $urandom_range(0, 127);
    if (r < 50)
      play(pva_pkg::FUNC_NOTE_ON, note, $urandom_range(1, 127), $urandom_range(0, 15));
    else if (r < 56)
      play(pva_pkg::FUNC_NOTE_ON, note, 0, $urandom_range(0, 15));
    else if (r < 74)
      play(pva_pkg::FUNC_NOTE_OFF, note, $urandom_range(0, 127), $urandom_range(0, 15));
    else if (r < 78)
      play(pva_pkg::FUNC_ALL_OFF, note, $urandom_range(0, 127), $urandom_range(0, 15));
    else
      play(pva_pkg::FUNC_VOICE_DONE, note, $urandom_range(0, 127), $urandom_range(0, 15));
  endtask

  initial begin
    logic [pva_pkg::MODE_W-1:0]  mode_tab  [7];
    logic [pva_pkg::LIMIT_W-1:0] limit_tab [7];
    logic [pva_pkg::MODE_W-1:0]  mode_sel;
    logic [pva_pkg::LIMIT_W-1:0] limit_sel;
    logic [pva_pkg::LIMIT_W-1:0] mode_word;
    bit use_pool;

    mode_tab  = '{2'd2, 2'd2, 2'd0, 2'd3, 2'd2, 2'd1, 2'd2};
    limit_tab = '{5'd16, 5'd31, 5'd16, 5'd5, 5'd1, 5'd0, 5'd3};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings, poly with limit 8
    play(pva_pkg::FUNC_NOTE_ON, 0, 127, 0);
    play(pva_pkg::FUNC_NOTE_ON, 127, 1, 15);
    play(pva_pkg::FUNC_NOTE_ON, 0, 0, 7);          // zero velocity, stops note 0
    play(pva_pkg::FUNC_NOTE_OFF, 5, 64, 3);        // nothing holds it
    play(pva_pkg::FUNC_NOTE_OFF, 127, 127, 0);
    play(pva_pkg::FUNC_ALL_OFF, 0, 0, 15);         // both slots still active
    play(pva_pkg::FUNC_VOICE_DONE, 127, 127, 0);
    play(pva_pkg::FUNC_VOICE_DONE, 0, 0, 15);
    play(pva_pkg::FUNC_VOICE_DONE, 0, 0, 1);
    play(pva_pkg::FUNC_ALL_OFF, 127, 127, 9);      // nothing active

    // Two usable slots: third and fourth note steal the oldest
    drain_results();
    program_register(pva_pkg::REG_VOICE_LIMIT, 5'd2);
    play(pva_pkg::FUNC_NOTE_ON, 60, 100, 0);
    play(pva_pkg::FUNC_NOTE_ON, 61, 90, 0);
    play(pva_pkg::FUNC_NOTE_ON, 62, 80, 0);
    play(pva_pkg::FUNC_NOTE_ON, 63, 70, 0);

    // Unused mode code acts as mono
    drain_results();
    program_register(pva_pkg::REG_VOICE_MODE, 5'd3);
    play(pva_pkg::FUNC_NOTE_ON, 64, 50, 0);
    play(pva_pkg::FUNC_ALL_OFF, 0, 0, 0);

    // Mono with limit 0
    drain_results();
    program_register(pva_pkg::REG_VOICE_MODE, 5'd0);
    program_register(pva_pkg::REG_VOICE_LIMIT, 5'd0);
    play(pva_pkg::FUNC_NOTE_ON, 65, 40, 0);
    play(pva_pkg::FUNC_VOICE_DONE, 0, 0, 0);
    play(pva_pkg::FUNC_VOICE_DONE, 0, 0, 1);
    play(pva_pkg::FUNC_NOTE_ON, 66, 30, 0);

    // Poly with limit 0 acts as a single slot
    drain_results();
    program_register(pva_pkg::REG_VOICE_MODE, 5'd2);
    play(pva_pkg::FUNC_NOTE_ON, 67, 20, 0);
    play(pva_pkg::FUNC_NOTE_ON, 127, 127, 0);

    // Mode 1 (acts as mono), limit above slot count
    drain_results();
    program_register(pva_pkg::REG_VOICE_MODE, 5'd1);
    program_register(pva_pkg::REG_VOICE_LIMIT, 5'd31);
    play(pva_pkg::FUNC_NOTE_ON, 1, 1, 0);

    // Random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      calm = (p % 4 == 1);
      if (p < 7) begin
        mode_sel  = mode_tab[p];
        limit_sel = limit_tab[p];
        mode_word = pva_pkg::LIMIT_W'(mode_sel);
      end else begin
        mode_sel  = pva_pkg::MODE_W'($urandom_range(0, 3));
        limit_sel = pva_pkg::LIMIT_W'($urandom_range(0, 31));
        mode_word = {3'($urandom_range(0, 7)), mode_sel};
      end
      if ($urandom_range(0, 1)) begin
        program_register(pva_pkg::REG_VOICE_MODE, mode_word);
        program_register(pva_pkg::REG_VOICE_LIMIT, limit_sel);
      end else begin
        program_register(pva_pkg::REG_VOICE_LIMIT, limit_sel);
        program_register(pva_pkg::REG_VOICE_MODE, mode_word);
      end
      use_pool = ($urandom_range(0, 3) != 0);
      note_pool[0] = 7'd0;
      note_pool[1] = 7'd127;
      for (int k = 2; k < 8; k++) note_pool[k] = pva_pkg::NOTE_W'($urandom_range(0, 127));
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // hold the sender until the allocator has caught up
        if (p % 3 == 2 && k == PHASE_ITEMS / 2) begin
          in_tvalid <= 1'b0;
          wait_for_results();
        end
        random_event(use_pool);
      end
    end

    drain_results();
    $display("Summary: %0d event beats sent, %0d voice beats checked, %0d register writes",
             beats_sent, events_checked, settings_used);
    if (mismatch_count == 0 && open_events == 0)
      $display("polyphonic_voice_allocator_unit test passed");
    else
      $display("polyphonic_voice_allocator_unit test failed");
    $finish;
  end

endmodule
